FILE: sv/ttts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tick task table scheduler.
// Depends on nothing; used by ttts_ctrl, ttts_dp and the top level.
package ttts_pkg;

   localparam int SLOTS_DEFAULT = 16;   // table depth
   localparam int RES_CAP       = 16;   // max dispatch results per request
   localparam int SLOT_W        = 4;    // width of the slot result field
   localparam int ID_W          = 8;
   localparam int TIME_W        = 16;
   localparam int PEND_W        = 8;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_ADD      = 3'd1,
      OP_DEL      = 3'd2,
      OP_DISPATCH = 3'd3,
      OP_STOP     = 3'd4
   } req_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

   // One table entry as kept in the slot memory.
   typedef struct packed {
      logic [ID_W-1:0]   task_id;
      logic [TIME_W-1:0] countdown;
      logic [TIME_W-1:0] period;
      logic [PEND_W-1:0] pending;
   } slot_entry_type;

   typedef struct packed {
      logic start;    // request transaction accepted this cycle
      logic scan;     // table scan in progress
      logic finish;   // load the final result of the request
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

FILE: sv/ttts_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer for the tick task table scheduler.
// Depends on ttts_pkg; drives commands into ttts_dp.
module ttts_ctrl
   import ttts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

FILE: sv/ttts_dp.sv
`timescale 1ns / 1ps
// Datapath: slot memory, occupancy bits, scan pipeline, result registers.
// Depends on ttts_pkg; sequenced by ttts_ctrl.
module ttts_dp
   import ttts_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic [2:0]          req_type,
   input  logic [ID_W-1:0]     task_id,
   input  logic [TIME_W-1:0]   first_delay,
   input  logic [TIME_W-1:0]   repeat_period,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_ok,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [ID_W-1:0]     rsp_run_id,
   output logic                rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int RES_W = $clog2(RES_CAP + 1);

   // latched request
   req_op_type        op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] delay_ff;
   logic [TIME_W-1:0] period_ff;

   // slot table
   slot_entry_type    mem [SLOTS];
   logic [SLOTS-1:0]  occ_ff;

   // scan pipeline: read stage and process stage
   logic [CNT_W-1:0]  rd_idx_ff;
   logic              p_valid_ff;
   logic [IDX_W-1:0]  p_idx_ff;
   slot_entry_type    p_entry_ff;
   logic              p_occ_ff;
   logic              stop_ff;
   logic [RES_W-1:0]  n_ff;

   // one dispatch result held back until we know whether it is the last
   logic              hold_valid_ff;
   logic [SLOT_W-1:0] hold_slot_ff;
   logic [ID_W-1:0]   hold_id_ff;

   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_last_ff;

   logic              act, stall, commit, advance, rd_en, out_free, op_known;
   logic              hit, emit, record, push;
   logic              wr_en, occ_set, occ_clr, default_ok;
   slot_entry_type    wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [SLOT_W-1:0] p_slot;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_addr  = rd_idx_ff[IDX_W-1:0];
   assign p_slot   = SLOT_W'(p_idx_ff);

   always_comb begin
      unique case (req_op_type'(req_type)) inside
         OP_TICK, OP_ADD, OP_DEL, OP_DISPATCH, OP_STOP: op_known = 1'b1;
         default:                                        op_known = 1'b0;
      endcase
   end

   // per-slot work of the process stage
   always_comb begin
      hit     = 1'b0;
      emit    = 1'b0;
      wr_en   = 1'b0;
      occ_set = 1'b0;
      occ_clr = 1'b0;
      wr_data = p_entry_ff;
      case (op_ff)
         OP_TICK: begin
            if (p_occ_ff) begin
               wr_en = 1'b1;
               if (p_entry_ff.countdown <= TIME_W'(1)) begin
                  if (p_entry_ff.pending != '1) wr_data.pending = p_entry_ff.pending + 1'b1;
                  if (p_entry_ff.period != '0) wr_data.countdown = p_entry_ff.period;
               end else begin
                  wr_data.countdown = p_entry_ff.countdown - 1'b1;
               end
            end
         end
         OP_STOP: begin
            if (p_occ_ff) begin
               wr_en           = 1'b1;
               wr_data.pending = '0;
            end
         end
         OP_ADD: begin
            if (!p_occ_ff && id_ff != '0) begin
               wr_en             = 1'b1;
               occ_set           = 1'b1;
               hit               = 1'b1;
               wr_data.task_id   = id_ff;
               wr_data.countdown = delay_ff;
               wr_data.period    = period_ff;
               wr_data.pending   = '0;
            end
         end
         OP_DEL: begin
            if (p_occ_ff && id_ff != '0 && p_entry_ff.task_id == id_ff) begin
               occ_clr = 1'b1;
               hit     = 1'b1;
            end
         end
         OP_DISPATCH: begin
            if (p_occ_ff && p_entry_ff.pending != '0) begin
               emit            = 1'b1;
               wr_data.pending = p_entry_ff.pending - 1'b1;
               // one-shot slot leaves the table once emitted
               if (p_entry_ff.period == '0) occ_clr = 1'b1;
               else                         wr_en   = 1'b1;
               if (n_ff == RES_W'(RES_CAP - 1)) hit = 1'b1;
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   assign act     = cmd.scan && p_valid_ff && !stop_ff;
   assign stall   = act && emit && hold_valid_ff && !out_free;
   assign commit  = act && !stall;
   assign advance = cmd.scan && !stall;
   assign rd_en   = advance && (rd_idx_ff < CNT_W'(SLOTS));
   assign record  = commit && (emit || hit);
   assign push    = commit && emit && hold_valid_ff;

   assign default_ok = (op_ff == OP_TICK) || (op_ff == OP_STOP);

   assign status = '{
      scan_done: stop_ff || (rd_idx_ff == CNT_W'(SLOTS) && !p_valid_ff),
      out_free:  out_free
   };

   // slot memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (commit && wr_en) mem[p_idx_ff] <= wr_data;
      if (rd_en) begin
         p_entry_ff <= mem[rd_addr];
         p_occ_ff   <= occ_ff[rd_addr];
         p_idx_ff   <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= req_op_type'(req_type);
         id_ff     <= task_id;
         delay_ff  <= first_delay;
         period_ff <= repeat_period;
      end
      if (record) begin
         hold_slot_ff <= p_slot;
         hold_id_ff   <= emit ? p_entry_ff.task_id : '0;
      end
      if (push) begin
         rsp_ok_ff   <= 1'b1;
         rsp_slot_ff <= hold_slot_ff;
         rsp_id_ff   <= hold_id_ff;
         rsp_last_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_ok_ff   <= hold_valid_ff ? 1'b1 : default_ok;
         rsp_slot_ff <= hold_valid_ff ? hold_slot_ff : '0;
         rsp_id_ff   <= hold_valid_ff ? hold_id_ff : '0;
         rsp_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff        <= '0;
         rd_idx_ff     <= '0;
         p_valid_ff    <= 1'b0;
         stop_ff       <= 1'b0;
         n_ff          <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (commit && occ_set) occ_ff[p_idx_ff] <= 1'b1;
         if (commit && occ_clr) occ_ff[p_idx_ff] <= 1'b0;

         if (cmd.start) begin
            rd_idx_ff  <= '0;
            p_valid_ff <= 1'b0;
            stop_ff    <= !op_known;
            n_ff       <= '0;
         end else begin
            if (advance) begin
               p_valid_ff <= rd_en;
               if (rd_en) rd_idx_ff <= rd_idx_ff + 1'b1;
            end
            if (commit && hit) stop_ff <= 1'b1;
            if (commit && emit) n_ff <= n_ff + 1'b1;
         end

         if (cmd.start || cmd.finish) hold_valid_ff <= 1'b0;
         else if (record)             hold_valid_ff <= 1'b1;

         if (push || cmd.finish)         rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_run_id = rsp_id_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: sv/tick_task_table_scheduler_top.sv
`timescale 1ns / 1ps
// Top level of the tick task table scheduler.
// Depends on ttts_pkg, ttts_ctrl and ttts_dp.
//
// Use: requests enter on the req_ stream (tuser = request type, tdata = task id,
// first delay, repeat period). Types: tick, add, delete, dispatch, stop.
// Each request gives one or more result transactions on the rsp_ stream;
// rsp_tlast marks the final result of a request. Dispatch gives one result
// per slot with a pending run (up to 16), in slot order.
// Scan: every request is a scan of the slot memory, one slot per cycle
// unless a dispatch stalls, with a registered read ahead of the update
// stage. Add and delete stop at the first matching slot; unknown types
// skip the scan. A new request is accepted once the last result has
// entered the output register, so one request is handled at a time.
// Stall: when rsp_tready is low the output register holds its transaction;
// a dispatch keeps one more result aside and then stops scanning until the
// output register frees up. Nothing is dropped.
// Reset (synchronous, active high) frees every slot at once through the
// occupancy bits; no clearing pass is needed.
module tick_task_table_scheduler_top
   import ttts_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // task_id[7:0], first_delay[23:8], repeat_period[39:24]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // slot[3:0], run_id[11:4], zero[15:12]
   output logic        rsp_tuser,   // ok[0]
   output logic        rsp_tlast
);

   ctrl_cmd_type      cmd;
   dp_status_type     status;
   logic [SLOT_W-1:0] rsp_slot;
   logic [ID_W-1:0]   rsp_run_id;

   // controller: accepts a request, runs the scan, hands off the final result
   ttts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: slot table, scan pipeline and result registers
   ttts_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_tuser),
      .task_id       (req_tdata[7:0]),
      .first_delay   (req_tdata[23:8]),
      .repeat_period (req_tdata[39:24]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_ok        (rsp_tuser),
      .rsp_slot      (rsp_slot),
      .rsp_run_id    (rsp_run_id),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_run_id, rsp_slot};

`ifndef SYNTHESIS
   // one request at a time: no second transaction right after an accept
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous request in flight");

   // a non-final result means the request is still being worked on
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("new request taken before final result issued");

   // failure results carry no slot and no task id
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'h0000)
      else $error("failure result with nonzero payload");
`endif

endmodule
